/* hdl/cde_pkg.sv */
// shared types and constants for the circular deque engine
// no dependencies; imported by circular_deque_engine

package cde_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_CLEAR      = 3'd4,
		ACT_REVERSE    = 3'd5,
		ACT_SORT       = 3'd6,
		ACT_PEEK       = 3'd7
	} cde_action_t;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned IN_W     = 40;
	localparam int unsigned OUT_W    = 80;
	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

endpackage

/* hdl/cde_ram.sv */
// generic simple dual-read ram: one write port, two registered read ports
// no dependencies; used by circular_deque_engine for the word store

module cde_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* hdl/circular_deque_engine.sv */
// circular deque engine: signed word deque in a circular ram with head, tail, count
// depends on cde_pkg and cde_ram
//
// push, pop, clear and peek update pointers and write, read head and tail, then load
//   the output register
// reverse reads each swapped pair, then writes its two words back one at a time; sort
//   reads and compares, n*(n-1)/2 compares for n stored words, and writes a swap one
//   word at a time through the single ram write port; input is held off until the
//   result is in the output register, which may still wait on the consumer
// reset (arst_n low, asynchronous): empty deque, head 0, tail DEPTH-1, no result

module circular_deque_engine
	import cde_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // action[2:0], value[34:3], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // front_value[31:0], back_value[63:32],
	                                    // count[71:64], is_empty[72], ignored[73], zero pad
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_LOAD,
		ST_REV_RD,
		ST_REV_W1,
		ST_REV_W2,
		ST_SRT_RD,
		ST_SRT_CMP,
		ST_SRT_W2
	} state_t;

	// wrap helpers for any depth, power of two or not
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
	endfunction

	state_t state_q;

	// deque bookkeeping
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] cnt_q;

	// walk registers shared by reverse (i, j, left) and sort (i, k, lim)
	logic [PW-1:0]     i_q;
	logic [PW-1:0]     j_q;
	logic [CW-1:0]     left_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     lim_q;
	logic [WORD_W-1:0] swap_q;
	logic              ign_q;

	// output register
	logic               m_tvalid_q;
	logic [WORD_W-1:0]  front_q;
	logic [WORD_W-1:0]  back_q;
	logic [COUNT_W-1:0] cnt_out_q;
	logic               empty_q;
	logic               ign_out_q;

	// ram ports
	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [PW-1:0]     ram_raddr_a;
	logic [PW-1:0]     ram_raddr_b;
	logic [WORD_W-1:0] ram_rdata_a;
	logic [WORD_W-1:0] ram_rdata_b;

	// input fields
	cde_action_t       in_action;
	logic [WORD_W-1:0] in_value;
	logic              in_fire;
	logic              is_full;
	logic              is_zero;
	logic [PW-1:0]     head_dec;
	logic [PW-1:0]     tail_inc;
	logic [PW-1:0]     srt_b;
	logic              srt_gt;
	logic              srt_last_k;
	logic              out_free;
	logic [CW+COUNT_W-1:0] cnt_ext;

	assign in_action = cde_action_t'(s_tdata[2:0]);
	assign in_value  = s_tdata[34:3];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;

	assign is_full  = (cnt_q == CW'(DEPTH));
	assign is_zero  = (cnt_q == '0);
	assign head_dec = ptr_dec(head_q);
	assign tail_inc = ptr_inc(tail_q);

	// sort compares entry i with its successor
	assign srt_b      = ptr_inc(i_q);
	assign srt_gt     = $signed(ram_rdata_a) > $signed(ram_rdata_b);
	assign srt_last_k = ((k_q + CW'(1)) == lim_q);

	assign out_free = !m_tvalid_q || m_tready;
	assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, ign_out_q, empty_q, cnt_out_q, back_q, front_q};

	// ram write and read address selection
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = head_dec;
		ram_wdata   = in_value;
		ram_raddr_a = head_q;
		ram_raddr_b = tail_q;
		case (state_q)
			ST_IDLE: begin
				// pushes write the slot the moving pointer lands on
				if (in_fire && !is_full &&
				    (in_action == ACT_PUSH_FRONT || in_action == ACT_PUSH_BACK)) begin
					ram_we    = 1'b1;
					ram_waddr = (in_action == ACT_PUSH_FRONT) ? head_dec : tail_inc;
				end
			end
			ST_REV_RD: begin
				ram_raddr_a = i_q;
				ram_raddr_b = j_q;
			end
			ST_REV_W1: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata_b;
			end
			ST_REV_W2: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = swap_q;
			end
			ST_SRT_RD: begin
				ram_raddr_a = i_q;
				ram_raddr_b = srt_b;
			end
			ST_SRT_CMP: begin
				ram_we    = srt_gt;
				ram_waddr = i_q;
				ram_wdata = ram_rdata_b;
			end
			ST_SRT_W2: begin
				ram_we    = 1'b1;
				ram_waddr = srt_b;
				ram_wdata = swap_q;
			end
			default: begin
				// read head and tail for the result
				ram_raddr_a = head_q;
				ram_raddr_b = tail_q;
			end
		endcase
	end

	cde_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	// sequencer: command decode, reverse and sort walks, result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= PW'(DEPTH - 1);
			cnt_q      <= '0;
			ign_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			left_q     <= '0;
			k_q        <= '0;
			lim_q      <= '0;
			swap_q     <= '0;
			m_tvalid_q <= 1'b0;
			front_q    <= '0;
			back_q     <= '0;
			cnt_out_q  <= '0;
			empty_q    <= 1'b0;
			ign_out_q  <= 1'b0;
		end else begin
			// the load state sets valid itself when it refills the register
			if (m_tvalid_q && m_tready && state_q != ST_LOAD) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ign_q   <= 1'b0;
						state_q <= ST_RD;
						case (in_action)
							ACT_PUSH_FRONT: begin
								if (is_full) begin
									ign_q <= 1'b1;
								end else begin
									head_q <= head_dec;
									cnt_q  <= cnt_q + CW'(1);
									if (is_zero) begin
										tail_q <= head_dec;
									end
								end
							end
							ACT_PUSH_BACK: begin
								if (is_full) begin
									ign_q <= 1'b1;
								end else begin
									tail_q <= tail_inc;
									cnt_q  <= cnt_q + CW'(1);
									if (is_zero) begin
										head_q <= tail_inc;
									end
								end
							end
							ACT_POP_FRONT: begin
								if (is_zero) begin
									ign_q <= 1'b1;
								end else begin
									head_q <= ptr_inc(head_q);
									cnt_q  <= cnt_q - CW'(1);
								end
							end
							ACT_POP_BACK: begin
								if (is_zero) begin
									ign_q <= 1'b1;
								end else begin
									tail_q <= ptr_dec(tail_q);
									cnt_q  <= cnt_q - CW'(1);
								end
							end
							ACT_CLEAR: begin
								head_q <= '0;
								tail_q <= PW'(DEPTH - 1);
								cnt_q  <= '0;
							end
							ACT_REVERSE: begin
								i_q    <= head_q;
								j_q    <= tail_q;
								left_q <= cnt_q;
								if (cnt_q > CW'(1)) begin
									state_q <= ST_REV_RD;
								end
							end
							ACT_SORT: begin
								i_q   <= head_q;
								k_q   <= '0;
								lim_q <= cnt_q - CW'(1);
								if (cnt_q > CW'(1)) begin
									state_q <= ST_SRT_RD;
								end
							end
							default: begin
								// peek: no change
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// read addresses hold on head and tail, so a stall keeps the data
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						front_q    <= is_zero ? EMPTY_WORD : ram_rdata_a;
						back_q     <= is_zero ? EMPTY_WORD : ram_rdata_b;
						cnt_out_q  <= cnt_ext[COUNT_W-1:0];
						empty_q    <= is_zero;
						ign_out_q  <= ign_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_REV_RD: begin
					state_q <= ST_REV_W1;
				end
				ST_REV_W1: begin
					swap_q  <= ram_rdata_a;
					state_q <= ST_REV_W2;
				end
				ST_REV_W2: begin
					i_q    <= ptr_inc(i_q);
					j_q    <= ptr_dec(j_q);
					left_q <= left_q - CW'(2);
					state_q <= (left_q > CW'(3)) ? ST_REV_RD : ST_RD;
				end
				ST_SRT_RD: begin
					state_q <= ST_SRT_CMP;
				end
				ST_SRT_CMP, ST_SRT_W2: begin
					if (state_q == ST_SRT_CMP && srt_gt) begin
						// larger word goes to the successor next cycle
						swap_q  <= ram_rdata_a;
						state_q <= ST_SRT_W2;
					end else if (srt_last_k) begin
						// end of a pass: shrink the unsorted span
						if (lim_q == CW'(1)) begin
							state_q <= ST_RD;
						end else begin
							lim_q   <= lim_q - CW'(1);
							k_q     <= '0;
							i_q     <= head_q;
							state_q <= ST_SRT_RD;
						end
					end else begin
						k_q     <= k_q + CW'(1);
						i_q     <= srt_b;
						state_q <= ST_SRT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill count never passes the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count above depth");

	// an empty deque always has tail one slot below head
	assert property (@(posedge clk) disable iff (!arst_n)
		is_zero |-> (tail_q == head_dec))
		else $error("empty deque with misplaced tail");

	// an accepted transaction blocks input on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input taken during command execution");

	// empty results carry all-ones words
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && empty_q) |-> (front_q == EMPTY_WORD && back_q == EMPTY_WORD))
		else $error("empty result with stale words");

	// a new result is loaded only when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !out_free) |=> (state_q == ST_LOAD))
		else $error("result dropped while output stalled");

endmodule
